>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the crossover block.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, muted while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

>>> hw/rtl/psmc_pkg.sv
// Shared types and fixed widths of the permutation swap-map crossover block.
// No dependencies.
package psmc_pkg;

   localparam int ELEM_W         = 6;
   localparam int MAP_DEPTH      = 64;
   localparam int GENE_LEN_W     = 7;
   localparam int SECT_LEN_W     = 7;
   localparam int GENE_LEN_RESET = 64;

   typedef logic [ELEM_W-1:0]     elem_type;
   typedef logic [GENE_LEN_W-1:0] gene_len_type;

endpackage

>>> hw/rtl/permutation_swap_map_crossover.sv
// Partially mapped crossover of two permutation genes, iterative datapath.
// Depends on psmc_pkg for element types and fixed field widths.
module permutation_swap_map_crossover
   import psmc_pkg::*;
#(
   parameter int MAX_GENE_LEN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  elem_type              req_gene_a,
   input  elem_type              req_gene_b,
   input  elem_type              req_section_start,
   input  logic [SECT_LEN_W-1:0] req_section_length,
   input  logic                  req_last,
   output logic                  rsp_strobe,
   output elem_type              rsp_child_a,
   output elem_type              rsp_child_b,
   output logic                  rsp_last_out,
   input  logic                  csr_write_en,
   input  gene_len_type          csr_wdata
);

   // Usage notes. Each item carries one position of parent A and parent B and is
   // taken into the next load position, starting from zero. Items without the
   // last flag cause no results and leave busy low. The item marked last also
   // brings the crossover section; the block then raises busy and works alone on
   // the pair. With L the gene length (the register clamped to the range two to
   // MAX_GENE_LEN), the run first reduces the section start modulo L on a
   // subtract-and-compare loop, then reads and checks each section position in
   // turn; a position that swaps also passes through a further write state, since
   // the swap map has a single write port and a swap writes two entries. Then
   // each result item passes through a parent store read, a swap map read and a
   // step that registers the result. Results are made one at a time, each on the
   // rsp_ ports while rsp_strobe is high for one cycle. The receiver cannot stall
   // the block, so it must take each result in the cycle it appears. Busy falls
   // in the cycle that shows the final result (rsp_last_out high), and a new item
   // may be taken in that same cycle. The gene length register may be written
   // only while busy is low. The swap map starts as the identity on each run
   // through a per-entry mapped bit that is cleared at once when the last item is
   // taken; an unmapped entry reads as its own index. Parent store entries that
   // were never loaded hold unknown data.

   localparam int POS_W = (MAX_GENE_LEN > 1) ? $clog2(MAX_GENE_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_GENE_LEN + 1);

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [POS_W-1:0] addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_SEC_RD,
      ST_SEC_CHK,
      ST_SEC_WR,
      ST_OUT_RD,
      ST_OUT_MAP,
      ST_OUT_EMIT
   } state_type;

   state_type              state_ff;
   gene_len_type           gene_length_ff;
   cnt_type                load_pos_ff;
   cnt_type                len_ff;
   cnt_type                count_ff;
   cnt_type                pos_ff;
   elem_type               rem_ff;
   logic [MAP_DEPTH-1:0]   mapped_ff;
   logic                   mapped_a_ff;
   logic                   mapped_b_ff;
   logic                   rsp_strobe_ff;
   elem_type               rsp_child_a_ff;
   elem_type               rsp_child_b_ff;
   logic                   rsp_last_out_ff;

   // Parent stores and swap map.
   elem_type               parent_a_mem [MAX_GENE_LEN];
   elem_type               parent_b_mem [MAX_GENE_LEN];
   elem_type               map_mem      [MAP_DEPTH];
   elem_type               a_rd_ff;
   elem_type               b_rd_ff;
   elem_type               map_a_ff;
   elem_type               map_b_ff;

   logic                   accept;
   logic                   load_room;
   cnt_type                eff_len;
   cnt_type                sect_count;
   logic                   pos_at_end;
   cnt_type                pos_next;
   logic                   do_swap;
   logic                   map_we;
   elem_type               map_waddr;
   elem_type               map_wdata;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign load_room = (32'(load_pos_ff) < MAX_GENE_LEN);

   // Effective gene length, clamped into the supported range.
   always_comb begin
      if (gene_length_ff < GENE_LEN_W'(2)) begin
         eff_len = CNT_W'(2);
      end else if (32'(gene_length_ff) > MAX_GENE_LEN) begin
         eff_len = CNT_W'(MAX_GENE_LEN);
      end else begin
         eff_len = CNT_W'(gene_length_ff);
      end
   end

   // Section length saturates at the gene length.
   always_comb begin
      if (32'(req_section_length) > 32'(eff_len)) begin
         sect_count = eff_len;
      end else begin
         sect_count = CNT_W'(req_section_length);
      end
   end

   assign pos_at_end = (pos_ff == (len_ff - CNT_W'(1)));
   assign pos_next   = pos_at_end ? '0 : (pos_ff + CNT_W'(1));

   // A swap needs both elements still unmapped; equal elements leave the map as it is.
   assign do_swap = !mapped_ff[a_rd_ff] && !mapped_ff[b_rd_ff] && (a_rd_ff != b_rd_ff);

   always_comb begin
      map_we    = 1'b0;
      map_waddr = a_rd_ff;
      map_wdata = b_rd_ff;
      case (state_ff)
         ST_SEC_CHK: begin
            map_we = do_swap;
         end
         ST_SEC_WR: begin
            map_we    = 1'b1;
            map_waddr = b_rd_ff;
            map_wdata = a_rd_ff;
         end
         default: begin
            map_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && load_room) begin
         parent_a_mem[addr_type'(load_pos_ff)] <= req_gene_a;
         parent_b_mem[addr_type'(load_pos_ff)] <= req_gene_b;
      end
      a_rd_ff <= parent_a_mem[addr_type'(pos_ff)];
      b_rd_ff <= parent_b_mem[addr_type'(pos_ff)];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_a_ff <= map_mem[a_rd_ff];
      map_b_ff <= map_mem[b_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         gene_length_ff  <= GENE_LEN_W'(GENE_LEN_RESET);
         load_pos_ff     <= '0;
         mapped_ff       <= '0;
         rsp_strobe_ff   <= 1'b0;
         len_ff          <= CNT_W'(2);
         count_ff        <= '0;
         pos_ff          <= '0;
         rem_ff          <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_write_en) begin
            gene_length_ff <= csr_wdata;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_last) begin
                     load_pos_ff <= '0;
                     len_ff      <= eff_len;
                     count_ff    <= sect_count;
                     rem_ff      <= req_section_start;
                     mapped_ff   <= '0;
                     state_ff    <= ST_MOD;
                  end else if (load_room) begin
                     load_pos_ff <= load_pos_ff + CNT_W'(1);
                  end
               end
            end
            ST_MOD: begin
               // One subtract per cycle until the start lies below the length.
               if (32'(rem_ff) >= 32'(len_ff)) begin
                  rem_ff <= rem_ff - ELEM_W'(len_ff);
               end else if (count_ff == '0) begin
                  pos_ff   <= '0;
                  state_ff <= ST_OUT_RD;
               end else begin
                  pos_ff   <= CNT_W'(rem_ff);
                  state_ff <= ST_SEC_RD;
               end
            end
            ST_SEC_RD: begin
               state_ff <= ST_SEC_CHK;
            end
            ST_SEC_CHK, ST_SEC_WR: begin
               if ((state_ff == ST_SEC_CHK) && do_swap) begin
                  mapped_ff[a_rd_ff] <= 1'b1;
                  state_ff           <= ST_SEC_WR;
               end else begin
                  if (state_ff == ST_SEC_WR) begin
                     mapped_ff[b_rd_ff] <= 1'b1;
                  end
                  count_ff <= count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     pos_ff   <= '0;
                     state_ff <= ST_OUT_RD;
                  end else begin
                     pos_ff   <= pos_next;
                     state_ff <= ST_SEC_RD;
                  end
               end
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_MAP;
            end
            ST_OUT_MAP: begin
               state_ff <= ST_OUT_EMIT;
            end
            ST_OUT_EMIT: begin
               rsp_strobe_ff <= 1'b1;
               if (pos_at_end) begin
                  state_ff <= ST_IDLE;
               end else begin
                  pos_ff   <= pos_ff + CNT_W'(1);
                  state_ff <= ST_OUT_RD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Result payload; mapped bits are sampled with the map read.
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT_MAP) begin
         mapped_a_ff <= mapped_ff[a_rd_ff];
         mapped_b_ff <= mapped_ff[b_rd_ff];
      end
      if (state_ff == ST_OUT_EMIT) begin
         rsp_child_a_ff  <= mapped_a_ff ? map_a_ff : a_rd_ff;
         rsp_child_b_ff  <= mapped_b_ff ? map_b_ff : b_rd_ff;
         rsp_last_out_ff <= pos_at_end;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_child_a  = rsp_child_a_ff;
   assign rsp_child_b  = rsp_child_b_ff;
   assign rsp_last_out = rsp_last_out_ff;

endmodule

>>> hw/rtl/psmc_checker.sv
// Port-level checker for the crossover block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module psmc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_strobe,
   input logic rsp_last_out
);

   // A final item starts a run; any other item is absorbed and busy stays low.
   `ASSERT_CLK(a_last_starts_run, (start && !busy && req_last) |=> busy, "run did not start")
   `ASSERT_CLK(a_load_no_busy, (start && !busy && !req_last) |=> !busy, "load item raised busy")
   // Results come only from a run, and never back to back.
   `ASSERT_CLK(a_strobe_in_run, rsp_strobe |-> (busy || $past(busy)), "result outside a run")
   `ASSERT_NEVER(a_strobe_spacing, rsp_strobe && $past(rsp_strobe), "results back to back")
   // The final result closes the run.
   `ASSERT_NEVER(a_last_ends_run, rsp_strobe && rsp_last_out && busy, "busy after last result")

endmodule

bind permutation_swap_map_crossover psmc_checker u_psmc_checker (.*);

>>> verif/psmc_crossover_checker.sv
// Scoreboard for the permutation swap-map crossover block: watches the item,
// result and register ports, predicts both children and compares them.
// Depends on psmc_pkg for the element and gene length types.
module psmc_crossover_checker
   import psmc_pkg::*;
#(
   parameter int MAX_GENE_LEN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  elem_type              req_gene_a,
   input  elem_type              req_gene_b,
   input  elem_type              req_section_start,
   input  logic [SECT_LEN_W-1:0] req_section_length,
   input  logic                  req_last,
   input  logic                  rsp_strobe,
   input  elem_type              rsp_child_a,
   input  elem_type              rsp_child_b,
   input  logic                  rsp_last_out,
   input  logic                  csr_write_en,
   input  gene_len_type          csr_wdata,
   output int                    mismatches,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      elem_type child_a;
      elem_type child_b;
      logic     last_out;
   } child_pos_type;

   elem_type      parent_a_mem [MAX_GENE_LEN];
   elem_type      parent_b_mem [MAX_GENE_LEN];
   int unsigned   load_pos;
   gene_len_type  gene_len;
   int            fail_count;
   child_pos_type expected_children [$];
   child_pos_type want;
   child_pos_type got;

   // Builds the swap map over the wrapped section, then queues one pair of
   // child elements per gene position.
   task automatic mate_parents(input elem_type sect_start,
                               input logic [SECT_LEN_W-1:0] sect_len);
      elem_type    swap_map [MAP_DEPTH];
      int unsigned len;
      int unsigned count;
      int unsigned pos;
      elem_type    ea;
      elem_type    eb;
      len = (gene_len < 2) ? 2 : ((gene_len > MAX_GENE_LEN) ? MAX_GENE_LEN : gene_len);
      count = (sect_len > len) ? len : sect_len;
      pos = sect_start % len;
      for (int i = 0; i < MAP_DEPTH; i++) swap_map[i] = elem_type'(i);
      for (int i = 0; i < count; i++) begin
         ea = parent_a_mem[pos];
         eb = parent_b_mem[pos];
         if (swap_map[ea] == ea && swap_map[eb] == eb) begin
            swap_map[ea] = eb;
            swap_map[eb] = ea;
         end
         pos = (pos == len - 1) ? 0 : pos + 1;
      end
      for (int k = 0; k < len; k++) begin
         expected_children.push_back(child_pos_type'{swap_map[parent_a_mem[k]],
                                                     swap_map[parent_b_mem[k]],
                                                     k == len - 1});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_pos = 0;
         gene_len = gene_len_type'(GENE_LEN_RESET);
         fail_count = 0;
         expected_children.delete();
         for (int i = 0; i < MAX_GENE_LEN; i++) begin
            parent_a_mem[i] = '0;
            parent_b_mem[i] = '0;
         end
         mismatches <= 0;
         pending <= 0;
      end else begin
         if (csr_write_en) gene_len = csr_wdata;
         if (start && !busy) begin
            if (load_pos < MAX_GENE_LEN) begin
               parent_a_mem[load_pos] = req_gene_a;
               parent_b_mem[load_pos] = req_gene_b;
               load_pos++;
            end
            if (req_last) begin
               load_pos = 0;
               mate_parents(req_section_start, req_section_length);
            end
         end
         if (rsp_strobe) begin
            got = child_pos_type'{rsp_child_a, rsp_child_b, rsp_last_out};
            if (expected_children.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("unexpected child item: a=%0d b=%0d last=%0d",
                           got.child_a, got.child_b, got.last_out);
            end else begin
               want = expected_children.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("child mismatch: expected a=%0d b=%0d last=%0d, got a=%0d b=%0d last=%0d",
                              want.child_a, want.child_b, want.last_out,
                              got.child_a, got.child_b, got.last_out);
               end
            end
         end
         mismatches <= fail_count;
         pending <= expected_children.size();
      end
   end

endmodule

>>> verif/permutation_swap_map_crossover_test.sv
// Top of the crossover regression: clock, reset, gene length settings and
// parent items for the block, with psmc_crossover_checker judging the children.
// Depends on psmc_pkg, the block itself and psmc_crossover_checker.
module permutation_swap_map_crossover_test;
   timeunit 1ns;
   timeprecision 1ps;
   import psmc_pkg::*;

   localparam int MAX_GENE_LEN   = 64;
   localparam int IDLE_PCT       = 22;
   localparam int RANDOM_ITEMS   = 450;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 200;
   // A full 64-element gene needs the section start reduction, a pass over
   // the section and an output pass; reaching this limit with no transfer
   // can only mean a hang.
   localparam int WATCHDOG_LIMIT = 4000;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  start              = 1'b0;
   logic                  busy;
   elem_type              req_gene_a         = '0;
   elem_type              req_gene_b         = '0;
   elem_type              req_section_start  = '0;
   logic [SECT_LEN_W-1:0] req_section_length = '0;
   logic                  req_last           = 1'b0;
   logic                  rsp_strobe;
   elem_type              rsp_child_a;
   elem_type              rsp_child_b;
   logic                  rsp_last_out;
   logic                  csr_write_en       = 1'b0;
   gene_len_type          csr_wdata          = '0;

   int mismatches;
   int pending;
   int idle_cycles = 0;

   // Stimulus bookkeeping. Positions of the parent stores that were never
   // loaded since reset must not be read, so every pair that is shorter
   // than the gene length is sized to cover them.
   bit          loaded_ever [MAP_DEPTH];
   bit          sender_idles = 1'b1;
   int unsigned eff_len = GENE_LEN_RESET;
   int unsigned items_sent = 0;

   always #2 clock = ~clock;

   permutation_swap_map_crossover #(
      .MAX_GENE_LEN(MAX_GENE_LEN)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_gene_a         (req_gene_a),
      .req_gene_b         (req_gene_b),
      .req_section_start  (req_section_start),
      .req_section_length (req_section_length),
      .req_last           (req_last),
      .rsp_strobe         (rsp_strobe),
      .rsp_child_a        (rsp_child_a),
      .rsp_child_b        (rsp_child_b),
      .rsp_last_out       (rsp_last_out),
      .csr_write_en       (csr_write_en),
      .csr_wdata          (csr_wdata)
   );

   psmc_crossover_checker #(
      .MAX_GENE_LEN(MAX_GENE_LEN)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_gene_a         (req_gene_a),
      .req_gene_b         (req_gene_b),
      .req_section_start  (req_section_start),
      .req_section_length (req_section_length),
      .req_last           (req_last),
      .rsp_strobe         (rsp_strobe),
      .rsp_child_a        (rsp_child_a),
      .rsp_child_b        (rsp_child_b),
      .rsp_last_out       (rsp_last_out),
      .csr_write_en       (csr_write_en),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   // The watchdog counts edges at which neither an item nor a child item
   // moves; any transfer restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("permutation_swap_map_crossover regression: fail");
      $finish;
   end

   // Offers one item and returns at the edge that takes it. Gaps go in front of
   // the item at random while sender_idles is set. Busy is looked at on the
   // falling edge, settled for the coming rising edge, so the take is race free.
   task automatic send_item(input elem_type a, input elem_type b,
                            input elem_type s_start,
                            input logic [SECT_LEN_W-1:0] s_len,
                            input logic is_last);
      while (sender_idles && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_gene_a         <= a;
      req_gene_b         <= b;
      req_section_start  <= s_start;
      req_section_length <= s_len;
      req_last           <= is_last;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   // Sends one parent pair, one item per position. Only the last item's
   // section fields count; the earlier ones carry random junk there.
   task automatic load_pair(input elem_type pa[$], input elem_type pb[$],
                            input elem_type s_start,
                            input logic [SECT_LEN_W-1:0] s_len);
      for (int i = 0; i < pa.size(); i++) begin
         if (i == pa.size() - 1) begin
            send_item(pa[i], pb[i], s_start, s_len, 1'b1);
         end else begin
            send_item(pa[i], pb[i], elem_type'($urandom_range(63)),
                      SECT_LEN_W'($urandom_range(127)), 1'b0);
         end
         if (i < MAP_DEPTH) loaded_ever[i] = 1'b1;
      end
   endtask

   // Drops start right after the last take and waits on the falling edge
   // until the checker holds no more expected child items.
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // The gene length is only changed with the block idle: all children out
   // and then a settling wait before the write.
   task automatic set_gene_length(input int unsigned value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_wdata    <= gene_len_type'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      eff_len = (value < 2) ? 2 : ((value > MAX_GENE_LEN) ? MAX_GENE_LEN : value);
   endtask

   // A well-formed pair is two shuffled permutations of the full gene. A noisy
   // pair has arbitrary elements and a length that may be short or run past
   // the gene, but never leaves an unloaded store position inside the gene.
   task automatic random_pair(input bit well_formed);
      elem_type                pa[$];
      elem_type                pb[$];
      elem_type                tmp;
      int unsigned             n;
      int unsigned             min_n;
      int unsigned             j;
      int unsigned             roll;
      elem_type                s_start;
      logic [SECT_LEN_W-1:0]   s_len;
      if (well_formed) begin
         for (int i = 0; i < eff_len; i++) begin
            pa.push_back(elem_type'(i));
            pb.push_back(elem_type'(i));
         end
         for (int i = eff_len - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = pa[i];
            pa[i] = pa[j];
            pa[j] = tmp;
            j = $urandom_range(i);
            tmp = pb[i];
            pb[i] = pb[j];
            pb[j] = tmp;
         end
      end else begin
         min_n = 1;
         for (int i = 0; i < eff_len; i++) begin
            if (!loaded_ever[i]) min_n = i + 1;
         end
         n = $urandom_range(eff_len + 4, min_n);
         for (int i = 0; i < n; i++) begin
            pa.push_back(elem_type'($urandom_range(63)));
            pb.push_back(elem_type'($urandom_range(63)));
         end
      end
      // Section start is sometimes inside the gene, sometimes anywhere in
      // the field so that it wraps modulo the gene length.
      s_start = ($urandom_range(1) == 0) ? elem_type'($urandom_range(eff_len - 1))
                                         : elem_type'($urandom_range(63));
      roll = $urandom_range(99);
      if (roll < 60) begin
         s_len = SECT_LEN_W'($urandom_range(eff_len, 1));
      end else if (roll < 75) begin
         s_len = '0;
      end else begin
         s_len = SECT_LEN_W'($urandom_range(127));
      end
      load_pair(pa, pb, s_start, s_len);
   endtask

   initial begin : stimulus
      int          phase;
      int unsigned next_len;
      int unsigned pairs;
      int unsigned item_goal;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A gene length of zero saturates to two elements.
      set_gene_length(0);
      // A one-position section swaps the only two elements.
      load_pair('{0, 1}, '{1, 0}, 0, 1);
      // A start past the end wraps; a zero section leaves the parents as they are.
      load_pair('{1, 0}, '{1, 0}, 63, 0);
      // A section longer than the gene saturates to the gene length.
      load_pair('{0, 1}, '{1, 0}, 1, 127);

      set_gene_length(4);
      // A full section that wraps from the end, where chained elements block
      // later swaps.
      load_pair('{0, 1, 2, 3}, '{1, 2, 3, 0}, 3, 4);
      // Element values at or past the gene length still index the map.
      load_pair('{63, 4, 2, 40}, '{5, 63, 2, 41}, 0, 4);
      // A pair of one item keeps the earlier contents of the other positions.
      load_pair('{3}, '{0}, 2, 2);
      // Items past the gene length are stored but do not reach the children.
      load_pair('{0, 1, 2, 3, 9, 10}, '{2, 3, 0, 1, 11, 12}, 1, 3);

      // Random part. Each phase picks a gene length, then sends a few pairs,
      // mostly well-formed. Phase changes wait for all children, so the
      // sender pauses with nothing in flight at every register write.
      item_goal = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < item_goal) begin
         case (phase)
            0: next_len = 127;
            1: next_len = 1;
            2: next_len = 64;
            3: next_len = 16;
            default: begin
               if ($urandom_range(99) < 80) begin
                  next_len = $urandom_range(12, 2);
               end else begin
                  next_len = $urandom_range(127, 13);
               end
            end
         endcase
         // Phase three runs back to back with no sender gaps at all.
         sender_idles = (phase != 3);
         set_gene_length(next_len);
         if (phase == 3) begin
            pairs = 8;
         end else if (eff_len > 32) begin
            pairs = $urandom_range(2, 1);
         end else begin
            pairs = $urandom_range(6, 3);
         end
         repeat (pairs) random_pair($urandom_range(99) < 75);
         phase++;
      end

      // Let the last children out, then give any stray child item time to show.
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("permutation_swap_map_crossover regression: pass");
      end else begin
         $display("permutation_swap_map_crossover regression: fail");
      end
      $finish;
   end

endmodule
